// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion reporting through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every rising clock edge out of reset
`define CHK_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/spo2rr_pkg.sv =====
// Package for the SpO2 ratio-of-ratios estimator: widths, constants, codes and types.
// No dependencies; used by the interfaces, the divider, the checker and the top level.
`timescale 1ns / 1ps
`default_nettype none
package spo2rr_pkg;

	localparam int HISTORY_DEPTH_DEF = 8;
	localparam int SAMPLE_BITS = 18;
	localparam int FRAC_BITS   = 8;
	localparam int DC_W        = SAMPLE_BITS + FRAC_BITS;   // unsigned DC state
	localparam int SM_W        = DC_W + 2;                  // signed smoothed state
	localparam int SLOPE_W     = SM_W + 1;
	localparam int COEF_W      = 16;
	localparam int TMO_W       = 8;
	localparam int MA_W        = COEF_W + 2;
	localparam int MB_W        = SM_W + 1;
	localparam int PROD_W      = MA_W + MB_W;
	localparam int ACC_W       = 58;
	localparam int ACC_SHIFT   = 16;
	localparam int RATIO_FRAC  = 20;
	localparam int R16_FRAC    = 16;
	localparam int R_W         = 40;
	localparam int SPLIT       = 20;                        // r16 split for two partial products
	localparam int RATIO_W     = 48;
	localparam int DIV_W       = 64;
	localparam int DEN_W       = 48;
	localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
	localparam int TERM_W      = 42;
	localparam int SPO2_CALC_W = TERM_W + 1;
	localparam int SPO2_W      = 15;
	localparam int SPO2_MAX    = 25600;
	localparam int QUAL_W      = 9;
	localparam int QUAL_ONE    = 256;
	localparam int QSUM_W      = 19;
	localparam int QPROD_W     = 29;
	localparam int QMAX_SUM    = (257 * (1 << RATIO_FRAC)) / 640;
	localparam int QUAL_MULT   = 640;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	localparam logic [COEF_W-1:0] DC_ALPHA_RST  = 16'd65208;
	localparam logic [COEF_W-1:0] LP_ALPHA_RST  = 16'd13107;
	localparam logic [COEF_W-1:0] RISE_RST      = 16'd1311;
	localparam logic [COEF_W-1:0] FALL_RST      = 16'd3;
	localparam logic [TMO_W-1:0]  TIMEOUT_RST   = 8'd200;
	localparam logic [COEF_W-1:0] CAL_OFF_RST   = 16'd28160;
	localparam logic [COEF_W-1:0] CAL_SLOPE_RST = 16'd6400;
	localparam logic [TMO_W-1:0]  CNT_SAT       = 8'd255;
	localparam logic [MA_W-1:0]   COEF_ONE      = 18'd65536;
	localparam logic [DC_W-1:0]   DC_ONE        = DC_W'(1 << FRAC_BITS);

	typedef enum logic [2:0] {
		REG_DC_ALPHA  = 3'd0,
		REG_LP_ALPHA  = 3'd1,
		REG_RISE      = 3'd2,
		REG_FALL      = 3'd3,
		REG_TIMEOUT   = 3'd4,
		REG_CAL_OFF   = 3'd5,
		REG_CAL_SLOPE = 3'd6
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DCR_A, S_DCR_B, S_DCI_A, S_DCI_B, S_LPR_A, S_LPR_B, S_LPI_A, S_LPI_B,
		S_THR, S_DECIDE, S_RR_GO, S_RR_WAIT, S_RI_GO, S_RI_WAIT, S_R16_GO, S_R16_WAIT,
		S_MUL_HI, S_MUL_LO, S_CHECK, S_AVG_GO, S_AVG_WAIT, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		MAC_HOLD, MAC_INIT, MAC_ADD, MAC_SHIFT, MAC_PLAIN
	} mac_op_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

endpackage
`default_nettype wire

// ===== design/spo2rr_if.sv =====
// Valid/ready channel interfaces for sample input and result output.
// Depends on spo2rr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface spo2rr_sample_if;
	logic                               valid;
	logic                               ready;
	logic [spo2rr_pkg::SAMPLE_BITS-1:0] red_sample;
	logic [spo2rr_pkg::SAMPLE_BITS-1:0] ir_sample;
	modport source (output valid, red_sample, ir_sample, input ready);
	modport sink (input valid, red_sample, ir_sample, output ready);
endinterface

interface spo2rr_result_if #(parameter int CNT_W = 4);
	logic                          valid;
	logic                          ready;
	logic [spo2rr_pkg::SPO2_W-1:0] spo2_average;
	logic                          average_valid;
	logic [CNT_W-1:0]              history_count;
	logic [spo2rr_pkg::QUAL_W-1:0] signal_quality;
	logic                          beat_closed;
	logic                          reading_accepted;
	modport source (output valid, spo2_average, average_valid, history_count,
		signal_quality, beat_closed, reading_accepted, input ready);
	modport sink (input valid, spo2_average, average_valid, history_count,
		signal_quality, beat_closed, reading_accepted, output ready);
endinterface
`default_nettype wire

// ===== design/spo2_ratio_of_ratios_estimator.sv =====
// SpO2 ratio-of-ratios estimator. One transaction in, one result out.
// A sample that closes no beat runs only the filter and beat-decision states; a closing
// beat with a reading adds four passes of the shared divider.
// The block takes a new sample only in idle, after the last one is done; a stalled result output holds it.
// Reset: arst_n clears filters, beat tracking, history count/sum and registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
module spo2_ratio_of_ratios_estimator #(
	parameter int HISTORY_DEPTH = spo2rr_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	spo2rr_sample_if.sink                 sample,
	spo2rr_result_if.source               result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [spo2rr_pkg::ADDR_W-1:0] paddr,
	input  logic [spo2rr_pkg::DATA_W-1:0] pwdata,
	output logic [spo2rr_pkg::DATA_W-1:0] prdata,
	output logic                          pready
);
	import spo2rr_pkg::*;

	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int HEAD_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int SUM_W  = SPO2_W + CNT_W;
	localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(32768);

	// ---------------- configuration ----------------
	logic [COEF_W-1:0] dc_alpha_q, lp_alpha_q, rise_q, fall_q, cal_off_q, cal_slope_q;
	logic [TMO_W-1:0]  timeout_q;
	reg_idx_t          reg_idx;
	logic              cfg_wr;

	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_alpha_q  <= DC_ALPHA_RST;
			lp_alpha_q  <= LP_ALPHA_RST;
			rise_q      <= RISE_RST;
			fall_q      <= FALL_RST;
			timeout_q   <= TIMEOUT_RST;
			cal_off_q   <= CAL_OFF_RST;
			cal_slope_q <= CAL_SLOPE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_DC_ALPHA:  dc_alpha_q  <= pwdata[COEF_W-1:0];
				REG_LP_ALPHA:  lp_alpha_q  <= pwdata[COEF_W-1:0];
				REG_RISE:      rise_q      <= pwdata[COEF_W-1:0];
				REG_FALL:      fall_q      <= pwdata[COEF_W-1:0];
				REG_TIMEOUT:   timeout_q   <= pwdata[TMO_W-1:0];
				REG_CAL_OFF:   cal_off_q   <= pwdata[COEF_W-1:0];
				REG_CAL_SLOPE: cal_slope_q <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_DC_ALPHA:  prdata = DATA_W'(dc_alpha_q);
			REG_LP_ALPHA:  prdata = DATA_W'(lp_alpha_q);
			REG_RISE:      prdata = DATA_W'(rise_q);
			REG_FALL:      prdata = DATA_W'(fall_q);
			REG_TIMEOUT:   prdata = DATA_W'(timeout_q);
			REG_CAL_OFF:   prdata = DATA_W'(cal_off_q);
			REG_CAL_SLOPE: prdata = DATA_W'(cal_slope_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------- state ----------------
	state_t state_q, state_n;

	logic [DC_W-1:0]        red_q, ir_q;
	logic [DC_W-1:0]        dc_red_q, dc_ir_q;
	logic signed [SM_W-1:0] smooth_red_q, smooth_ir_q, prev_ir_q;
	logic signed [SM_W-1:0] peak_ir_q, trough_ir_q, peak_red_q, trough_red_q;
	logic                   beat_open_q;
	logic [TMO_W-1:0]       since_q;
	logic [HEAD_W-1:0]      head_q;
	logic [CNT_W-1:0]       count_q;
	logic [SUM_W-1:0]       sum_q;
	logic [QUAL_W-1:0]      quality_q;
	logic [SPO2_W-1:0]      avg_q;
	logic                   closed_q, accepted_q;

	logic signed [ACC_W-1:0] acc_q, acc_n;
	logic [SM_W-2:0]         dred_q;
	logic [SM_W-2:0]         dir_q;
	logic [RATIO_W-1:0]      rr_q, ri_q;
	logic [R_W-1:0]          r16_q;

	logic [SPO2_W-1:0] ring [HISTORY_DEPTH];
	logic [SPO2_W-1:0] rd_q;

	logic              out_valid_q;
	logic [SPO2_W-1:0] out_avg_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [QUAL_W-1:0] out_qual_q;
	logic              out_closed_q, out_acc_q;

	// ---------------- shared multiplier ----------------
	mac_op_t                  mac_op;
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod;
	logic [MA_W-1:0]          n_dc, n_lp;

	assign n_dc = COEF_ONE - {2'b0, dc_alpha_q};
	assign n_lp = COEF_ONE - {2'b0, lp_alpha_q};
	assign prod = mul_a * mul_b;

	always_comb begin
		case (mac_op)
			MAC_INIT:  acc_n = ACC_ROUND + prod;
			MAC_ADD:   acc_n = acc_q + prod;
			MAC_SHIFT: acc_n = (acc_q <<< SPLIT) + prod + ACC_ROUND;
			MAC_PLAIN: acc_n = ACC_W'(prod);
			default:   acc_n = acc_q;
		endcase
	end

	// ---------------- divider ----------------
	div_req_t         div_req;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	spo2rr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---------------- beat decision terms ----------------
	logic signed [SLOPE_W-1:0] slope;
	logic [SM_W-1:0]           mag, thr;
	logic [TMO_W-1:0]          since_inc;
	logic                      rise_hit, fall_hit, time_hit, closing;
	logic signed [SM_W-1:0]    pk_ir_n, tr_ir_n, pk_red_n, tr_red_n;
	logic signed [SLOPE_W-1:0] dir_w, dred_w;
	logic signed [SLOPE_W:0]   fall_sum;
	logic                      dir_pos;
	logic [DC_W-1:0]           dcr_eff, dci_eff;

	assign slope     = SLOPE_W'(smooth_ir_q) - SLOPE_W'(prev_ir_q);
	assign mag       = prev_ir_q[SM_W-1] ? SM_W'(-prev_ir_q) : prev_ir_q;
	assign thr       = acc_q[ACC_SHIFT +: SM_W];
	assign rise_hit  = slope > $signed({1'b0, thr});
	assign since_inc = (since_q != CNT_SAT) ? since_q + 1'b1 : since_q;
	assign pk_ir_n   = (smooth_ir_q > peak_ir_q) ? smooth_ir_q : peak_ir_q;
	assign tr_ir_n   = (smooth_ir_q < trough_ir_q) ? smooth_ir_q : trough_ir_q;
	assign pk_red_n  = (smooth_red_q > peak_red_q) ? smooth_red_q : peak_red_q;
	assign tr_red_n  = (smooth_red_q < trough_red_q) ? smooth_red_q : trough_red_q;
	assign fall_sum  = (SLOPE_W + 1)'(slope) + $signed({{(SLOPE_W - COEF_W){1'b0}}, fall_q});
	assign fall_hit  = fall_sum[SLOPE_W];
	assign time_hit  = since_inc > timeout_q;
	assign closing   = fall_hit || time_hit;
	assign dir_w     = SLOPE_W'(pk_ir_n) - SLOPE_W'(tr_ir_n);
	assign dred_w    = SLOPE_W'(pk_red_n) - SLOPE_W'(tr_red_n);
	assign dir_pos   = !dir_w[SLOPE_W-1] && (dir_w != '0);
	assign dcr_eff   = (dc_red_q != '0) ? dc_red_q : DC_ONE;
	assign dci_eff   = (dc_ir_q != '0) ? dc_ir_q : DC_ONE;

	// ---------------- reading terms ----------------
	logic [TERM_W-1:0]             term;
	logic signed [SPO2_CALC_W-1:0] spo2_w;
	logic                          in_range;
	logic [RATIO_W:0]              qsum;
	logic [QPROD_W-1:0]            qprod;
	logic [QUAL_W-1:0]             qual_n;
	logic                          ring_full;
	logic [SPO2_W-1:0]             reading;
	logic [CNT_W-1:0]              count_n;
	logic [SUM_W-1:0]              sum_n;
	logic                          push;

	assign term      = acc_q[ACC_SHIFT +: TERM_W];
	assign spo2_w    = $signed({{(SPO2_CALC_W - COEF_W){1'b0}}, cal_off_q})
		- $signed({1'b0, term});
	assign in_range  = !spo2_w[SPO2_CALC_W-1] && (spo2_w <= SPO2_CALC_W'(SPO2_MAX));
	assign qsum      = {1'b0, rr_q} + {1'b0, ri_q};
	assign qprod     = QPROD_W'(qsum[QSUM_W-1:0]) * QPROD_W'(QUAL_MULT);
	assign qual_n    = (qsum > (RATIO_W + 1)'(QMAX_SUM)) ? QUAL_W'(QUAL_ONE)
		: qprod[QPROD_W-1 -: QUAL_W];
	assign ring_full = count_q >= CNT_W'(HISTORY_DEPTH);
	assign reading   = spo2_w[SPO2_W-1:0];
	assign count_n   = ring_full ? count_q : count_q + 1'b1;
	assign sum_n     = ring_full ? sum_q - SUM_W'(rd_q) + SUM_W'(reading)
		: sum_q + SUM_W'(reading);
	assign push      = (state_q == S_CHECK) && in_range;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE:     if (sample.valid) state_n = S_DCR_A;
			S_DCR_A:    state_n = S_DCR_B;
			S_DCR_B:    state_n = S_DCI_A;
			S_DCI_A:    state_n = S_DCI_B;
			S_DCI_B:    state_n = S_LPR_A;
			S_LPR_A:    state_n = S_LPR_B;
			S_LPR_B:    state_n = S_LPI_A;
			S_LPI_A:    state_n = S_LPI_B;
			S_LPI_B:    state_n = S_THR;
			S_THR:      state_n = S_DECIDE;
			S_DECIDE:   state_n = (beat_open_q && closing && dir_pos) ? S_RR_GO : S_DONE;
			S_RR_GO:    state_n = S_RR_WAIT;
			S_RR_WAIT:  if (div_done) state_n = S_RI_GO;
			S_RI_GO:    state_n = S_RI_WAIT;
			S_RI_WAIT:  if (div_done) state_n = (div_quo == '0) ? S_DONE : S_R16_GO;
			S_R16_GO:   state_n = S_R16_WAIT;
			S_R16_WAIT: if (div_done) state_n = S_MUL_HI;
			S_MUL_HI:   state_n = S_MUL_LO;
			S_MUL_LO:   state_n = S_CHECK;
			S_CHECK:    state_n = in_range ? S_AVG_GO : S_DONE;
			S_AVG_GO:   state_n = S_AVG_WAIT;
			S_AVG_WAIT: if (div_done) state_n = S_DONE;
			S_DONE:     if (!out_valid_q || result.ready) state_n = S_IDLE;
			default:    state_n = S_IDLE;
		endcase
	end

	always_comb begin
		mac_op        = MAC_HOLD;
		mul_a         = '0;
		mul_b         = '0;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		case (state_q)
			S_DCR_A: begin
				mac_op = MAC_INIT;
				mul_a  = $signed({2'b0, dc_alpha_q});
				mul_b  = $signed({3'b0, dc_red_q});
			end
			S_DCR_B: begin
				mac_op = MAC_ADD;
				mul_a  = $signed(n_dc);
				mul_b  = $signed({3'b0, red_q});
			end
			S_DCI_A: begin
				mac_op = MAC_INIT;
				mul_a  = $signed({2'b0, dc_alpha_q});
				mul_b  = $signed({3'b0, dc_ir_q});
			end
			S_DCI_B: begin
				mac_op = MAC_ADD;
				mul_a  = $signed(n_dc);
				mul_b  = $signed({3'b0, ir_q});
			end
			S_LPR_A: begin
				mac_op = MAC_INIT;
				mul_a  = $signed({2'b0, lp_alpha_q});
				mul_b  = MB_W'(smooth_red_q);
			end
			S_LPR_B: begin
				mac_op = MAC_ADD;
				mul_a  = $signed(n_lp);
				mul_b  = $signed({3'b0, red_q}) - $signed({3'b0, dc_red_q});
			end
			S_LPI_A: begin
				mac_op = MAC_INIT;
				mul_a  = $signed({2'b0, lp_alpha_q});
				mul_b  = MB_W'(smooth_ir_q);
			end
			S_LPI_B: begin
				mac_op = MAC_ADD;
				mul_a  = $signed(n_lp);
				mul_b  = $signed({3'b0, ir_q}) - $signed({3'b0, dc_ir_q});
			end
			S_THR: begin
				mac_op = MAC_PLAIN;
				mul_a  = $signed({2'b0, rise_q});
				mul_b  = $signed({1'b0, mag});
			end
			S_RR_GO: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_W'({dred_q, {RATIO_FRAC{1'b0}}});
				div_req.den   = DEN_W'(dcr_eff);
			end
			S_RI_GO: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_W'({dir_q, {RATIO_FRAC{1'b0}}});
				div_req.den   = DEN_W'(dci_eff);
			end
			S_R16_GO: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_W'({rr_q, {R16_FRAC{1'b0}}});
				div_req.den   = ri_q;
			end
			S_MUL_HI: begin
				mac_op = MAC_PLAIN;
				mul_a  = $signed({2'b0, cal_slope_q});
				mul_b  = $signed(MB_W'(r16_q[R_W-1:SPLIT]));
			end
			S_MUL_LO: begin
				mac_op = MAC_SHIFT;
				mul_a  = $signed({2'b0, cal_slope_q});
				mul_b  = $signed(MB_W'(r16_q[SPLIT-1:0]));
			end
			S_AVG_GO: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_W'(sum_q + SUM_W'(count_q >> 1));
				div_req.den   = DEN_W'(count_q);
			end
			default: ;
		endcase
	end

	// ---------------- datapath with reset ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_red_q     <= '0;
			dc_ir_q      <= '0;
			smooth_red_q <= '0;
			smooth_ir_q  <= '0;
			prev_ir_q    <= '0;
			peak_ir_q    <= '0;
			trough_ir_q  <= '0;
			peak_red_q   <= '0;
			trough_red_q <= '0;
			beat_open_q  <= 1'b0;
			since_q      <= '0;
			head_q       <= '0;
			count_q      <= '0;
			sum_q        <= '0;
			quality_q    <= '0;
			avg_q        <= '0;
			closed_q     <= 1'b0;
			accepted_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						closed_q   <= 1'b0;
						accepted_q <= 1'b0;
					end
				end
				S_DCI_A: dc_red_q     <= acc_q[ACC_SHIFT +: DC_W];
				S_LPR_A: dc_ir_q      <= acc_q[ACC_SHIFT +: DC_W];
				S_LPI_A: smooth_red_q <= acc_q[ACC_SHIFT +: SM_W];
				S_THR:   smooth_ir_q  <= acc_q[ACC_SHIFT +: SM_W];
				S_DECIDE: begin
					prev_ir_q <= smooth_ir_q;
					if (!beat_open_q) begin
						if (rise_hit) begin
							beat_open_q  <= 1'b1;
							peak_ir_q    <= smooth_ir_q;
							trough_ir_q  <= smooth_ir_q;
							peak_red_q   <= smooth_red_q;
							trough_red_q <= smooth_red_q;
							since_q      <= '0;
						end else begin
							since_q <= since_inc;
						end
					end else if (closing) begin
						closed_q     <= 1'b1;
						beat_open_q  <= 1'b0;
						peak_ir_q    <= '0;
						trough_ir_q  <= '0;
						peak_red_q   <= '0;
						trough_red_q <= '0;
						since_q      <= '0;
					end else begin
						peak_ir_q    <= pk_ir_n;
						trough_ir_q  <= tr_ir_n;
						peak_red_q   <= pk_red_n;
						trough_red_q <= tr_red_n;
						since_q      <= since_inc;
					end
				end
				S_CHECK: begin
					if (in_range) begin
						count_q    <= count_n;
						sum_q      <= sum_n;
						head_q     <= (head_q == HEAD_W'(HISTORY_DEPTH - 1)) ? '0
							: head_q + 1'b1;
						quality_q  <= qual_n;
						accepted_q <= 1'b1;
					end
				end
				S_AVG_WAIT: if (div_done) avg_q <= div_quo[SPO2_W-1:0];
				default: ;
			endcase

			if (state_q == S_DONE && (!out_valid_q || result.ready)) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	// ---------------- datapath payload ----------------
	always_ff @(posedge clk) begin
		acc_q <= acc_n;
		if (state_q == S_IDLE && sample.valid) begin
			red_q <= {sample.red_sample, {FRAC_BITS{1'b0}}};
			ir_q  <= {sample.ir_sample, {FRAC_BITS{1'b0}}};
		end
		if (state_q == S_DECIDE) begin
			dir_q  <= dir_w[SM_W-2:0];
			dred_q <= dred_w[SLOPE_W-1] ? '0 : dred_w[SM_W-2:0];
		end
		if (state_q == S_RR_WAIT && div_done) rr_q <= div_quo[RATIO_W-1:0];
		if (state_q == S_RI_WAIT && div_done) ri_q <= div_quo[RATIO_W-1:0];
		if (state_q == S_R16_WAIT && div_done)
			r16_q <= (div_quo > DIV_W'({R_W{1'b1}})) ? {R_W{1'b1}} : div_quo[R_W-1:0];
		if (state_q == S_DONE && (!out_valid_q || result.ready)) begin
			out_avg_q    <= avg_q;
			out_count_q  <= count_q;
			out_qual_q   <= quality_q;
			out_closed_q <= closed_q;
			out_acc_q    <= accepted_q;
		end
	end

	// history memory, read port registered
	always_ff @(posedge clk) begin
		if (push) ring[head_q] <= reading;
		rd_q <= ring[head_q];
	end

	// ---------------- ports ----------------
	assign sample.ready            = (state_q == S_IDLE);
	assign result.valid            = out_valid_q;
	assign result.spo2_average     = out_avg_q;
	assign result.average_valid    = (out_count_q != '0);
	assign result.history_count    = out_count_q;
	assign result.signal_quality   = out_qual_q;
	assign result.beat_closed      = out_closed_q;
	assign result.reading_accepted = out_acc_q;
endmodule
`default_nettype wire

// ===== design/spo2rr_div.sv =====
// Restoring divider, one quotient bit per cycle, DIV_W quotient bits per transaction.
// Depends on spo2rr_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none
module spo2rr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  spo2rr_pkg::div_req_t         req,
	output logic                         done,
	output logic [spo2rr_pkg::DIV_W-1:0] quotient
);
	import spo2rr_pkg::*;

	logic [DIV_W-1:0]     num_q;    // dividend shifts out the top, quotient in the bottom
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DEN_W:0]       shifted;
	logic [DEN_W:0]       diff;
	logic                 ge;

	assign shifted = {rem_q, num_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= DIV_CNT_W'(DIV_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			num_q <= {num_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;
endmodule
`default_nettype wire

// ===== design/spo2rr_checker.sv =====
// Port-level checker for the SpO2 estimator, bound to the top level.
// Depends on spo2rr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spo2rr_checker #(
	parameter int HISTORY_DEPTH = spo2rr_pkg::HISTORY_DEPTH_DEF
) (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_ready,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic [spo2rr_pkg::SPO2_W-1:0]        spo2_average,
	input wire logic                                 average_valid,
	input wire logic [$clog2(HISTORY_DEPTH+1)-1:0]   history_count,
	input wire logic [spo2rr_pkg::QUAL_W-1:0]        signal_quality,
	input wire logic                                 beat_closed,
	input wire logic                                 reading_accepted
);
	import spo2rr_pkg::*;

	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

	`CHK_ALWAYS(a_avg_valid, clk, arst_n, !out_valid || (average_valid == (history_count != '0)), "average_valid disagrees with history_count")
	`CHK_ALWAYS(a_accept_needs_close, clk, arst_n, !out_valid || !reading_accepted || beat_closed, "reading accepted without a closed beat")
	`CHK_ALWAYS(a_count_range, clk, arst_n, !out_valid || (history_count <= CNT_W'(HISTORY_DEPTH)), "history_count beyond depth")
	`CHK_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "input taken again while busy")
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(spo2_average) && $stable(history_count) && $stable(signal_quality), "stalled result changed")
endmodule

bind spo2_ratio_of_ratios_estimator spo2rr_checker #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (sample.valid),
	.in_ready         (sample.ready),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.spo2_average     (result.spo2_average),
	.average_valid    (result.average_valid),
	.history_count    (result.history_count),
	.signal_quality   (result.signal_quality),
	.beat_closed      (result.beat_closed),
	.reading_accepted (result.reading_accepted)
);
`default_nettype wire
